@@ hw/rtl/esq_pkg.sv @@
// esq_pkg: shared types and constants for the event scheduler queue
// no dependencies; imported by esq_ctrl, esq_datapath, event_scheduler_queue and event_scheduler_queue_test
package esq_pkg;
    localparam int NUM_KINDS  = 16;
    localparam int CYCLE_BITS = 31;
    localparam int KIND_W     = $clog2(NUM_KINDS);
    localparam int SCAN_W     = $clog2(NUM_KINDS + 1);

    typedef logic [CYCLE_BITS-1:0] cycle_t;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_POLL   = 3'd2,
        REQ_QUERY  = 3'd3,
        REQ_SETBK  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIRE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;     // capture request
        logic exec;     // non-poll ops, including set-back
        logic scan;     // one poll comparison step
        logic scan_clr; // start scan
        logic fire;     // finish poll
        logic out_load; // present result
    } cmd_t;

    typedef struct packed {
        logic is_poll;
        logic scan_done;
    } stat_t;
endpackage

@@ hw/rtl/event_scheduler_queue.sv @@
// event_scheduler_queue: top level of the timed event scheduler
// depends on esq_pkg, esq_ctrl, esq_datapath
// One transaction in gives one result. Insert, remove, query, set-back and unknown requests
// pass through the execute and output states before m_tvalid rises, and the next request can
// be accepted in the same cycle that m_tvalid rises. Poll passes through the execute state, a
// serial scan over the slots with one due-cycle compare each cycle, and the fire and output
// states before m_tvalid rises. One request is in flight at a time; the result register lets
// the next request in while the last result waits, and a stalled m_tready holds the following
// request until the result register frees up.
module event_scheduler_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // req_type[2:0], event_kind[6:3], cycle_amount[37:7],
                                  // now_cycle[68:38], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // event_fired[0], fired_kind[4:1], query_pending[5],
                                  // query_cycle[36:6], zero pad
);
    import esq_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  busy, out_free, in_fire;
    logic  fired, qpend;
    logic [3:0] fkind;
    cycle_t qcyc;
    logic  m_tvalid_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b0, qcyc, qpend, fkind, fired};

    esq_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_free, .stat, .cmd, .busy
    );

    esq_datapath u_dp (
        .aclk, .aresetn, .cmd,
        .req_type     (s_tdata[2:0]),
        .event_kind   (s_tdata[6:3]),
        .cycle_amount (s_tdata[37:7]),
        .now_cycle    (s_tdata[68:38]),
        .stat,
        .res_kind     (fkind),
        .res_fired    (fired),
        .res_qpend    (qpend),
        .res_qcyc     (qcyc)
    );

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_no_overwrite;
        @(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

    property p_fire_excl;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[5];
    endproperty
    a_fire_excl: assert property (p_fire_excl) else $error("poll and query both set");
endmodule

@@ hw/rtl/esq_ctrl.sv @@
// esq_ctrl: request sequencer for the event scheduler queue
// depends on esq_pkg
module esq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           out_free,
    input  esq_pkg::stat_t stat,
    output esq_pkg::cmd_t  cmd,
    output logic           busy
);
    import esq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.is_poll) begin
                    cmd.scan_clr = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    cmd.exec = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) state_next = ST_FIRE;
            end
            ST_FIRE: begin
                cmd.fire = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/esq_datapath.sv @@
// esq_datapath: slot store, age matrix, poll scan and set-back for the scheduler
// depends on esq_pkg
module esq_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  esq_pkg::cmd_t            cmd,
    input  logic [2:0]               req_type,
    input  logic [3:0]               event_kind,
    input  logic [esq_pkg::CYCLE_BITS-1:0] cycle_amount,
    input  logic [esq_pkg::CYCLE_BITS-1:0] now_cycle,
    output esq_pkg::stat_t           stat,
    output logic [3:0]               res_kind,
    output logic                     res_fired,
    output logic                     res_qpend,
    output logic [esq_pkg::CYCLE_BITS-1:0] res_qcyc
);
    import esq_pkg::*;

    cycle_t                   due_reg [NUM_KINDS];
    logic [NUM_KINDS-1:0]     pend_reg;
    logic [NUM_KINDS-1:0]     older_reg [NUM_KINDS];
    logic [2:0]               req_reg;
    logic [3:0]               kind_reg;
    cycle_t                   amt_reg, now_reg;
    logic [SCAN_W-1:0]        idx_reg;
    logic                     best_vld_reg;
    logic [KIND_W-1:0]        best_reg;
    logic                     fired_reg, qpend_reg;
    logic [3:0]               fkind_reg;
    cycle_t                   qcyc_reg;

    logic                     kind_ok;
    logic [KIND_W-1:0]        k;
    logic [CYCLE_BITS:0]      sum;
    cycle_t                   ins_val;
    logic [KIND_W-1:0]        cur;
    logic                     cur_wins;

    assign kind_ok = ({1'b0, kind_reg} < 5'(NUM_KINDS));
    assign k       = kind_reg[KIND_W-1:0];
    assign sum     = {1'b0, now_reg} + {1'b0, amt_reg};
    assign ins_val = sum[CYCLE_BITS] ? '1 : sum[CYCLE_BITS-1:0];
    assign cur     = idx_reg[KIND_W-1:0];
    // pending candidate beats current best: no best yet, earlier due, or same due and older
    assign cur_wins = pend_reg[cur] && (!best_vld_reg ||
                      (due_reg[cur] < due_reg[best_reg]) ||
                      (due_reg[cur] == due_reg[best_reg] && older_reg[cur][best_reg]));

    assign stat.is_poll   = (req_reg == REQ_POLL);
    assign stat.scan_done = (idx_reg == SCAN_W'(NUM_KINDS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req_type;
            kind_reg <= event_kind;
            amt_reg  <= cycle_amount;
            now_reg  <= now_cycle;
        end
        if (cmd.scan_clr) begin
            idx_reg <= '0;
            best_vld_reg <= 1'b0;
            best_reg <= '0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            if (cur_wins) begin
                best_vld_reg <= 1'b1;
                best_reg <= cur;
            end
        end
        if (cmd.exec) begin
            fired_reg <= 1'b0;
            fkind_reg <= '0;
            qpend_reg <= 1'b0;
            qcyc_reg  <= '0;
            if (req_reg == REQ_QUERY && kind_ok && pend_reg[k]) begin
                qpend_reg <= 1'b1;
                qcyc_reg  <= due_reg[k];
            end
            if (req_reg == REQ_INSERT && kind_ok) due_reg[k] <= ins_val;
            if (req_reg == REQ_SETBK) begin
                for (int i = 0; i < NUM_KINDS; i++) begin
                    if (pend_reg[i])
                        due_reg[i] <= (due_reg[i] > amt_reg) ? due_reg[i] - amt_reg : '0;
                end
            end
        end
        if (cmd.fire) begin
            qpend_reg <= 1'b0;
            qcyc_reg  <= '0;
            fired_reg <= 1'b0;
            fkind_reg <= '0;
            if (best_vld_reg && due_reg[best_reg] <= now_reg) begin
                fired_reg <= 1'b1;
                fkind_reg <= 4'(best_reg);
            end
        end
        if (cmd.out_load) begin
            res_fired <= fired_reg;
            res_kind  <= fkind_reg;
            res_qpend <= qpend_reg;
            res_qcyc  <= qcyc_reg;
        end
    end

    // pending bits and age matrix reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            for (int i = 0; i < NUM_KINDS; i++) older_reg[i] <= '0;
        end else if (cmd.exec) begin
            if (req_reg == REQ_INSERT && kind_ok) begin
                pend_reg[k] <= 1'b1;
                for (int i = 0; i < NUM_KINDS; i++) begin
                    if (i == int'(k)) older_reg[i] <= '0;
                    else older_reg[i][k] <= 1'b1;
                end
            end
            if (req_reg == REQ_REMOVE && kind_ok) pend_reg[k] <= 1'b0;
            if (req_reg == REQ_SETBK) begin
                // new order follows the old precedence among pending slots
                for (int i = 0; i < NUM_KINDS; i++) begin
                    for (int j = 0; j < NUM_KINDS; j++) begin
                        older_reg[i][j] <= (i != j) && pend_reg[i] && pend_reg[j] &&
                            ((due_reg[i] < due_reg[j]) ||
                             (due_reg[i] == due_reg[j] && older_reg[i][j]));
                    end
                end
            end
        end else if (cmd.fire) begin
            if (best_vld_reg && due_reg[best_reg] <= now_reg) pend_reg[best_reg] <= 1'b0;
        end
    end

    property p_fire_pending;
        @(posedge aclk) disable iff (!aresetn)
        (cmd.fire && best_vld_reg) |-> pend_reg[best_reg];
    endproperty
    a_fire_pending: assert property (p_fire_pending) else $error("best slot not pending");

    property p_cleared;
        @(posedge aclk) disable iff (!aresetn)
        (cmd.fire && best_vld_reg && due_reg[best_reg] <= now_reg) |=> !pend_reg[$past(best_reg)];
    endproperty
    a_cleared: assert property (p_cleared) else $error("fired slot still pending");

    property p_scan_bound;
        @(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> idx_reg < SCAN_W'(NUM_KINDS);
    endproperty
    a_scan_bound: assert property (p_scan_bound) else $error("scan index overrun");
endmodule

@@ verif/event_scheduler_queue_test.sv @@
// event_scheduler_queue_test: self-checking stream testbench for the event scheduler queue
// depends on esq_pkg and event_scheduler_queue; predicts each result and compares per field
module event_scheduler_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import esq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic       fired;
        logic [3:0] kind;
        logic       pending;
        cycle_t     cyc;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    event_scheduler_queue DUT (.*);

    always #10 aclk = ~aclk;

    // predictor state
    cycle_t         due_q [NUM_KINDS];
    logic           armed [NUM_KINDS];
    logic [15:0]    older [NUM_KINDS];
    sched_result_t  expected_results [$];
    logic [71:0]    pending_reqs [$];
    int             err_count = 0;
    int             watchdog = 0;
    bit             hold_sender = 1'b0;
    bit             stim_done = 1'b0;
    int             s_gap = 0;
    int             m_gap = 0;

    function automatic logic [71:0] pack_req(req_t r, logic [3:0] k, cycle_t a, cycle_t n);
        return {3'b000, n, a, k, 3'(r)};
    endfunction

    function automatic void queue_req(logic [71:0] r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic void queue_expect(sched_result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic bit ahead_of(int a, int b);
        if (due_q[a] != due_q[b]) return due_q[a] < due_q[b];
        return older[a][b];
    endfunction

    function automatic sched_result_t schedule_step(logic [71:0] d);
        logic [2:0]     r;
        logic [3:0]     k;
        cycle_t         amt;
        cycle_t         now;
        logic [31:0]    sum;
        logic [15:0]    reorder [NUM_KINDS];
        sched_result_t  res;
        bit             best;
        r = d[2:0];
        k = d[6:3];
        amt = d[37:7];
        now = d[68:38];
        res = '0;
        case (r)
            REQ_INSERT: begin
                sum = {1'b0, now} + {1'b0, amt};
                due_q[k] = sum[31] ? '1 : sum[30:0];
                armed[k] = 1'b1;
                older[k] = '0;
                for (int j = 0; j < NUM_KINDS; j++)
                    if (j != k) older[j][k] = 1'b1;
            end
            REQ_REMOVE: armed[k] = 1'b0;
            REQ_POLL: begin
                for (int i = 0; i < NUM_KINDS; i++) begin
                    best = armed[i];
                    for (int j = 0; j < NUM_KINDS; j++)
                        if (best && j != i && armed[j] && !ahead_of(i, j)) best = 0;
                    if (best) begin
                        if (due_q[i] <= now) begin
                            res.fired = 1'b1;
                            res.kind = 4'(i);
                            armed[i] = 1'b0;
                        end
                        break;
                    end
                end
            end
            REQ_QUERY: begin
                if (armed[k]) begin
                    res.pending = 1'b1;
                    res.cyc = due_q[k];
                end
            end
            REQ_SETBK: begin
                for (int i = 0; i < NUM_KINDS; i++) begin
                    reorder[i] = '0;
                    for (int j = 0; j < NUM_KINDS; j++)
                        if (j != i && armed[i] && armed[j] && ahead_of(i, j))
                            reorder[i][j] = 1'b1;
                end
                for (int i = 0; i < NUM_KINDS; i++) begin
                    if (armed[i]) due_q[i] = due_q[i] > amt ? due_q[i] - amt : '0;
                    older[i] = reorder[i];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_expect(schedule_step(s_tdata));
                void'(pending_reqs.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the current transaction
            end else if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_reqs[0];
                s_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[4:1], m_tdata[5], m_tdata[36:6]};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.fired != want.fired)
                        report_mismatch("event_fired", got.fired, want.fired);
                    if (got.kind != want.kind) report_mismatch("fired_kind", got.kind, want.kind);
                    if (got.pending != want.pending)
                        report_mismatch("query_pending", got.pending, want.pending);
                    if (got.cyc != want.cyc) report_mismatch("query_cycle", got.cyc, want.cyc);
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) m_gap <= pick_gap();
            end
        end
    end

    function automatic cycle_t rand_cycle();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return cycle_t'($urandom_range(0, 64));
            3: return cycle_t'($urandom_range(0, 2000));
            default: return cycle_t'($urandom);
        endcase
    endfunction

    initial begin
        logic [71:0] raw;
        cycle_t      now;
        int          p;
        for (int i = 0; i < NUM_KINDS; i++) begin
            due_q[i] = '0;
            armed[i] = 1'b0;
            older[i] = '0;
        end
        // directed: extremes, saturation, equal-cycle ties, set-back clamp, odd requests
        queue_req(pack_req(REQ_POLL, 4'd0, '0, '1));
        queue_req(pack_req(REQ_QUERY, 4'd15, '1, '0));
        queue_req(pack_req(REQ_INSERT, 4'd15, '1, '1));
        queue_req(pack_req(REQ_QUERY, 4'd15, '0, '0));
        queue_req(pack_req(REQ_INSERT, 4'd3, 31'd5, 31'd10));
        queue_req(pack_req(REQ_INSERT, 4'd1, 31'd0, 31'd15));
        queue_req(pack_req(REQ_INSERT, 4'd0, 31'd10, 31'd20));
        queue_req(pack_req(REQ_POLL, 4'd0, '0, 31'd14));
        queue_req(pack_req(REQ_SETBK, 4'd0, 31'd100, '0));
        queue_req(pack_req(REQ_QUERY, 4'd0, '0, '0));
        queue_req(pack_req(REQ_POLL, 4'd0, '0, '0));
        queue_req(pack_req(REQ_POLL, 4'd0, '0, '0));
        queue_req(pack_req(REQ_REMOVE, 4'd15, '0, '0));
        queue_req(pack_req(REQ_QUERY, 4'd15, '0, '0));
        queue_req(pack_req(REQ_POLL, 4'd0, '0, '1));
        queue_req(pack_req(REQ_SETBK, 4'd0, '1, '1));
        queue_req({3'b000, 31'h7fffffff, 31'h7fffffff, 4'hf, 3'd5});
        queue_req({3'b000, 31'h0, 31'h0, 4'h0, 3'd7});
        queue_req(pack_req(REQ_POLL, 4'd0, '0, '1));
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // pause the sender once until every result is home
        wait (pending_reqs.size() == 0);
        @(posedge aclk);
        hold_sender <= 1'b1;
        wait (expected_results.size() == 0 && !s_tvalid);
        @(posedge aclk);
        hold_sender <= 1'b0;
        // random: mostly insert/poll traffic on a moving clock, some noise
        now = '0;
        for (int n = 0; n < 450; n++) begin
            p = $urandom_range(0, 99);
            if ($urandom_range(0, 40) == 0) now = rand_cycle();
            else now = now + cycle_t'($urandom_range(0, 6));
            if (p < 35) raw = pack_req(REQ_INSERT, 4'($urandom), ($urandom_range(0, 9) == 0)
                                       ? rand_cycle() : cycle_t'($urandom_range(0, 20)), now);
            else if (p < 70) raw = pack_req(REQ_POLL, 4'($urandom), rand_cycle(), now);
            else if (p < 78) raw = pack_req(REQ_REMOVE, 4'($urandom), rand_cycle(), now);
            else if (p < 90) raw = pack_req(REQ_QUERY, 4'($urandom), rand_cycle(), now);
            else if (p < 96) raw = pack_req(REQ_SETBK, 4'($urandom),
                                   ($urandom_range(0, 3) == 0) ? rand_cycle()
                                   : cycle_t'($urandom_range(0, 10)), now);
            else raw = {3'b000, 31'($urandom), 31'($urandom), 4'($urandom),
                        3'($urandom_range(5, 7))};
            queue_req(raw);
            if (pending_reqs.size() > 8) wait (pending_reqs.size() < 4);
        end
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (40) @(posedge aclk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done || watchdog >= WATCHDOG_LIMIT);
        if (stim_done) begin
            if (err_count == 0) begin
                $display("Test completed successfully");
            end else begin
                $display("Test completed with failures");
            end
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/esq_pkg.sv
hw/rtl/esq_ctrl.sv
hw/rtl/esq_datapath.sv
hw/rtl/event_scheduler_queue.sv
verif/event_scheduler_queue_test.sv
